FILE: sv/tkpc_pkg.sv
// ----------------------------------------------------------------------------
// tkpc_pkg
// shared types and constants of the two key press classifier
// ----------------------------------------------------------------------------
package tkpc_pkg;

  // width of the internal timestamp, differences wrap modulo 2^TimeBits
  localparam int unsigned TimeBits = 32;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned StampW   = 32;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgLongThr = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDblWin  = 1'b1;

  typedef logic [TimeBits-1:0] time_t;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvShort  = 2'd1,
    EvLong   = 2'd2,
    EvDouble = 2'd3
  } event_e;

  typedef struct packed {
    logic [CfgDataW-1:0] long_thr;
    logic [CfgDataW-1:0] dbl_win;
  } cfg_t;

endpackage

FILE: sv/tkpc_key.sv
// ----------------------------------------------------------------------------
// tkpc_key
// per-key press state and short / long / double classification
// ----------------------------------------------------------------------------
module tkpc_key import tkpc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   step_i,
  input  logic   down_i,
  input  time_t  now_i,
  input  cfg_t   cfg_i,
  output event_e event_o
);

  logic   prev_q, prev_d;
  time_t  press_q, press_d;
  time_t  rel_q, rel_d;
  time_t  single_q, single_d;
  logic   long_q, long_d;
  logic   dbl_q, dbl_d;
  logic   sgl_q, sgl_d;
  event_e ev_q, ev_d;

  time_t thr, win;

  assign thr = time_t'(cfg_i.long_thr);
  assign win = time_t'(cfg_i.dbl_win);

  always_comb begin
    prev_d   = down_i;
    press_d  = press_q;
    rel_d    = rel_q;
    single_d = single_q;
    long_d   = long_q;
    dbl_d    = dbl_q;
    sgl_d    = sgl_q;
    ev_d     = ev_q;

    // pending single turns into short once the window has passed
    if (sgl_q && ((now_i - single_q) >= win)) begin
      ev_d  = EvShort;
      sgl_d = 1'b0;
    end

    if (down_i) begin
      if (!prev_q) begin
        press_d = now_i;
        ev_d    = EvNone;
      end
      if (!long_q && ((now_i - press_d) > thr)) begin
        ev_d   = EvLong;
        long_d = 1'b1;
        dbl_d  = 1'b0;
        sgl_d  = 1'b0;
      end else if (long_q) begin
        ev_d = EvLong;
      end
    end else begin
      if (prev_q) begin
        if (!long_q) begin
          if (dbl_q && ((now_i - rel_q) < win)) begin
            ev_d  = EvDouble;
            dbl_d = 1'b0;
            sgl_d = 1'b0;
          end else begin
            sgl_d    = 1'b1;
            single_d = now_i;
            dbl_d    = 1'b1;
            rel_d    = now_i;
          end
        end
        long_d = 1'b0;
      end else if (dbl_q && ((now_i - rel_q) >= win)) begin
        dbl_d = 1'b0;
      end
      press_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      press_q  <= '0;
      rel_q    <= '0;
      single_q <= '0;
      long_q   <= 1'b0;
      dbl_q    <= 1'b0;
      sgl_q    <= 1'b0;
      ev_q     <= EvNone;
    end else if (step_i) begin
      prev_q   <= prev_d;
      press_q  <= press_d;
      rel_q    <= rel_d;
      single_q <= single_d;
      long_q   <= long_d;
      dbl_q    <= dbl_d;
      sgl_q    <= sgl_d;
      ev_q     <= ev_d;
    end
  end

  assign event_o = ev_d;

endmodule

FILE: sv/two_key_press_classifier.sv
// ----------------------------------------------------------------------------
// two_key_press_classifier
// short, long and double press detection for two keys plus a combo pulse
// ----------------------------------------------------------------------------
// Each request on the input stream is one poll: the debounced levels of two
// keys and a free-running millisecond timestamp. Every poll gives exactly one
// request on the output stream holding the latest event of each key (none,
// short, long, double) and a one-poll combo flag raised when both keys first
// go down together. The block takes one poll per clock cycle while the output
// is not stalled. A poll passes through the input register and then the
// result register; the per-key events are computed combinationally between
// them. Timestamp differences wrap modulo 2^32. The user must write the two
// thresholds through the config port only while no poll is in flight; the
// block itself does not enforce this. Both thresholds reset to their defaults.
// ----------------------------------------------------------------------------
module two_key_press_classifier import tkpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // [0] key_a_down, [1] key_b_down,
                                                // [33:2] time_ms, [39:34] zero
  // output stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // [1:0] key_a_event,
                                                // [3:2] key_b_event,
                                                // [4] combo_event, [7:5] zero
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  cfg_t cfg_q, cfg_d;

  // input register
  logic  in_vld_q;
  logic  in_a_q, in_b_q;
  time_t in_now_q;

  // result register
  logic                out_vld_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  // combo tracking
  logic combo_seen_q, combo_seen_d, combo_pulse;

  logic   step;     // item in the input register moves to the result
  logic   in_take;  // new poll accepted
  event_e ev_a, ev_b;

  // the input register frees up whenever its poll moves on
  assign step            = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || step;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLongThr: cfg_d.long_thr = cfg_data_i;
        CfgDblWin:  cfg_d.dbl_win  = cfg_data_i;
        default:    cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_thr <= CfgDataW'(1000);
      cfg_q.dbl_win  <= CfgDataW'(300);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_a_q   <= s_axis_tdata_i[0];
      in_b_q   <= s_axis_tdata_i[1];
      in_now_q <= time_t'(s_axis_tdata_i[StampW+1:2]);
    end
  end

  // per-key classifiers, state advances once per poll
  tkpc_key u_key_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .down_i  (in_a_q),
    .now_i   (in_now_q),
    .cfg_i   (cfg_q),
    .event_o (ev_a)
  );

  tkpc_key u_key_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .down_i  (in_b_q),
    .now_i   (in_now_q),
    .cfg_i   (cfg_q),
    .event_o (ev_b)
  );

  // combo pulse only on the first poll with both keys down
  assign combo_seen_d = in_a_q && in_b_q;
  assign combo_pulse  = in_a_q && in_b_q && !combo_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      combo_seen_q <= 1'b0;
    end else if (step) begin
      combo_seen_q <= combo_seen_d;
    end
  end

  // result packing
  assign out_data_d = {3'b000, combo_pulse, 2'(ev_b), 2'(ev_a)};

  // result stage, holds while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

FILE: sv/tkpc_checker.sv
// ----------------------------------------------------------------------------
// tkpc_checker
// port-level checks for the two key press classifier
// ----------------------------------------------------------------------------
module tkpc_checker import tkpc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // an empty output side never blocks new polls
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // a poll taken with nothing ahead reaches the output through the input and result registers
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o) |-> ##2 m_axis_tvalid_o)
    else $error("result missing after poll");

  // stalled result holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

endmodule

bind two_key_press_classifier tkpc_checker u_tkpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
